/* rtl/core/fp32_fp16_converter_assert.svh */
// Assertion macros for the fp32/fp16 converter.
// Used by the converter RTL; no other dependencies.
`ifndef FP32_FP16_CONVERTER_ASSERT_SVH
`define FP32_FP16_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FCV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FCV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FCV_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define FCV_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/fcv_pkg.sv */
// Shared types and constants for the fp32/fp16 converter.
// No dependencies.
`default_nettype none
package fcv_pkg;
   localparam int unsigned CsrIdxWidth = 1;
   localparam int unsigned CsrDataWidth = 1;
   localparam logic [CsrIdxWidth-1:0] CSR_DIRECTION = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_HALF_BYPASS = 1'd1;

   typedef struct packed {
      logic direction;
      logic half_bypass;
   } cfg_type;
endpackage
`default_nettype wire

/* rtl/core/fcv_narrow.sv */
// Combinational binary32 -> binary16 narrowing with round-to-nearest-even.
// Depends on nothing but plain logic.
`default_nettype none
module fcv_narrow (
   input  wire logic [31:0] value,
   output logic [15:0]      half
);
   logic        sign;
   logic [7:0]  e;
   logic [22:0] m;
   logic [14:0] v;
   logic [12:0] rem;
   logic [23:0] s;
   logic [6:0]  shift;
   logic [23:0] q;
   logic [23:0] srem;
   logic [23:0] halfway;
   logic [24:0] mask;

   always_comb begin
      sign = value[31];
      e = value[30:23];
      m = value[22:0];
      v = {5'(e - 8'd112), m[22:13]};
      rem = m[12:0];
      s = {1'b1, m};
      shift = 7'(8'd126 - e);
      q = s >> shift[4:0];
      mask = (25'd1 << shift[4:0]) - 25'd1;
      srem = s & mask[23:0];
      halfway = 24'd1 << (shift[4:0] - 5'd1);
      half = {sign, 15'd0};
      if (e == 8'hFF) begin
         half = (m != 23'd0) ? {sign, 5'h1F, 1'b1, m[21:13]} : {sign, 15'h7C00};
      end else if (e > 8'd142) begin
         half = {sign, 15'h7C00};
      end else if (e >= 8'd113) begin
         if (rem > 13'h1000 || (rem == 13'h1000 && v[0])) begin
            v = v + 15'd1;
         end
         half = {sign, v};
      end else if (e != 8'd0 && e >= 8'd102) begin
         // subnormal result: shift 14..24
         if (srem > halfway || (srem == halfway && q[0])) begin
            q = q + 24'd1;
         end
         half = {sign, q[14:0]};
      end
   end
endmodule
`default_nettype wire

/* rtl/core/fcv_widen.sv */
// Combinational binary16 -> binary32 exact widening.
// Depends on nothing but plain logic.
`default_nettype none
module fcv_widen (
   input  wire logic [15:0] half,
   output logic [31:0]      value
);
   logic       sign;
   logic [4:0] he;
   logic [9:0] hm;
   logic [3:0] p;
   logic [9:0] norm;

   always_comb begin
      sign = half[15];
      he = half[14:10];
      hm = half[9:0];
      // locate leading one of the subnormal fraction
      p = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (hm[i]) begin
            p = 4'(i);
         end
      end
      norm = 10'(hm << (4'd10 - p));
      if (he == 5'h1F) begin
         // NaN keeps its payload with the quiet bit forced
         value = (hm != 10'd0) ? {sign, 8'hFF, 1'b1, hm[8:0], 13'd0}
                               : {sign, 31'h7F800000};
      end else if (he == 5'd0) begin
         value = (hm == 10'd0) ? {sign, 31'd0}
                               : {sign, 8'(8'd103 + 8'(p)), norm, 13'd0};
      end else begin
         value = {sign, 8'(8'd112 + 8'(he)), hm, 13'd0};
      end
   end
endmodule
`default_nettype wire

/* rtl/core/fp32_fp16_converter.sv */
// fp32/fp16 converter: start passes the input register, then the result
// register, on its way to rsp_valid; throughput one request every cycle.
// Rate set by one pass of narrow/widen logic between the two registers.
// busy is always low; the receiver cannot stall. Synchronous active-high
// reset clears the configuration and the valid bits.
// Depends on fcv_pkg, fcv_narrow, fcv_widen and the assertion header.
`default_nettype none
`include "fp32_fp16_converter_assert.svh"
module fp32_fp16_converter
   import fcv_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [31:0]             req_value_in,
   input  wire logic                    req_last_in,
   output logic                         rsp_valid,
   output logic [31:0]                  rsp_value_out,
   output logic                         rsp_last_out,
   input  wire logic                    csr_write,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_data
);
   cfg_type     cfg_ff;
   logic        in_valid_ff;
   logic [31:0] in_value_ff;
   logic        in_last_ff;
   logic        out_valid_ff;
   logic [31:0] out_value_ff, out_value_in;
   logic        out_last_ff;
   logic [15:0] half_res;
   logic [31:0] wide_res;

   assign busy = 1'b0;

   // hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DIRECTION:   cfg_ff.direction <= csr_data[0];
            CSR_HALF_BYPASS: cfg_ff.half_bypass <= csr_data[0];
            default: ;
         endcase
      end
   end

   // capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
      in_value_ff <= req_value_in;
      in_last_ff <= req_last_in;
   end

   fcv_narrow u_narrow (.value(in_value_ff), .half(half_res));
   fcv_widen  u_widen  (.half(in_value_ff[15:0]), .value(wide_res));

   // select result
   always_comb begin
      if (cfg_ff.half_bypass) begin
         out_value_in = in_value_ff;
      end else if (cfg_ff.direction) begin
         out_value_in = wide_res;
      end else begin
         out_value_in = {16'd0, half_res};
      end
   end

   // advance result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid_ff;
      end
      out_value_ff <= out_value_in;
      out_last_ff <= in_last_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value_out = out_value_ff;
   assign rsp_last_out = out_last_ff;

   `FCV_ASSERT_NXT(a_lat, clock, reset, start, ##1 rsp_valid, "result latency broken")
   `FCV_ASSERT_NXT(a_last, clock, reset, start, ##1 (rsp_last_out == $past(req_last_in, 2)), "last mark lost")
   `FCV_ASSERT_IMP(a_narrow_hi, clock, reset, rsp_valid && !$past(cfg_ff.half_bypass) && !$past(cfg_ff.direction), rsp_value_out[31:16] == 16'd0, "narrow upper bits set")
endmodule
`default_nettype wire

/* bench/fp32_fp16_converter_tb.sv */
// Self-checking bench for the fp32/fp16 converter: drives requests and config
// writes, predicts each response in a scoreboard class. Depends on fcv_pkg and fp32_fp16_converter.
`timescale 1ns / 1ps

class conv_scoreboard;
   logic [31:0] want_value[$];
   logic        want_last[$];
   bit          cfg_direction;
   bit          cfg_bypass;
   int          errors;

   // Narrow binary32 to binary16, round to nearest even
   function logic [15:0] to_half(logic [31:0] x);
      logic [15:0] sgn;
      logic [7:0]  e;
      logic [22:0] m;
      logic [15:0] v;
      logic [12:0] rem;
      logic [23:0] s;
      logic [23:0] q;
      logic [23:0] r;
      logic [23:0] half_pt;
      int          sh;
      sgn = {x[31], 15'd0};
      e = x[30:23];
      m = x[22:0];
      if (e == 8'hFF) begin
         if (m != 0) return sgn | 16'h7E00 | {6'd0, m[22:13]};
         return sgn | 16'h7C00;
      end
      if (e > 142) return sgn | 16'h7C00;
      if (e >= 113) begin
         v = {e - 8'd112, 10'd0} | {6'd0, m[22:13]};
         rem = m[12:0];
         if (rem > 13'h1000 || (rem == 13'h1000 && v[0])) v = v + 1;
         return sgn | v;
      end
      if (e == 0) return sgn;
      sh = 126 - e;
      if (sh >= 25) return sgn;
      s = {1'b1, m};
      q = s >> sh;
      r = s & ((24'd1 << sh) - 1);
      half_pt = 24'd1 << (sh - 1);
      if (r > half_pt || (r == half_pt && q[0])) q = q + 1;
      return sgn | q[15:0];
   endfunction

   // Widen binary16 to binary32 exactly
   function logic [31:0] to_single(logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  he;
      logic [9:0]  hm;
      int          p;
      sgn = {h[15], 31'd0};
      he = h[14:10];
      hm = h[9:0];
      if (he == 5'h1F) begin
         if (hm != 0) return sgn | 32'h7FC00000 | ({22'd0, hm} << 13);
         return sgn | 32'h7F800000;
      end
      if (he == 0) begin
         if (hm == 0) return sgn;
         p = 9;
         while (!hm[p]) p--;
         return sgn | (32'(p + 103) << 23) | ((32'(hm) << (23 - p)) & 32'h7FFFFF);
      end
      return sgn | (32'(he + 112) << 23) | (32'(hm) << 13);
   endfunction

   function void note_request(logic [31:0] value, logic last);
      if (cfg_bypass) want_value.push_back(value);
      else if (!cfg_direction) want_value.push_back({16'd0, to_half(value)});
      else want_value.push_back(to_single(value[15:0]));
      want_last.push_back(last);
   endfunction

   function void check_response(logic [31:0] value, logic last);
      logic [31:0] ev;
      logic        el;
      if (want_value.size() == 0) begin
         $display("%0t: unexpected response value %h last %b", $time, value, last);
         errors++;
         return;
      end
      ev = want_value.pop_front();
      el = want_last.pop_front();
      if (value !== ev) begin
         $display("%0t: value mismatch expected %h actual %h", $time, ev, value);
         errors++;
      end
      if (last !== el) begin
         $display("%0t: last mismatch expected %b actual %b", $time, el, last);
         errors++;
      end
   endfunction
endclass

module fp32_fp16_converter_tb;
   import fcv_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [31:0] req_value_in = 0;
   logic req_last_in = 0;
   logic rsp_valid;
   logic [31:0] rsp_value_out;
   logic rsp_last_out;
   logic csr_write = 0;
   logic [CsrIdxWidth-1:0] csr_index = CSR_DIRECTION;
   logic [CsrDataWidth-1:0] csr_data = 0;

   conv_scoreboard conv_board = new();
   int idle_pct = 0;
   int quiet_cycles = 0;

   fp32_fp16_converter dut (.*);

   always #1 clock = ~clock;

   // Check responses and count cycles with no traffic
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) conv_board.check_response(rsp_value_out, rsp_last_out);
         if ((start && !busy) || rsp_valid) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > 2000) begin
            $display("fp32_fp16_converter_tb NOT OK");
            $finish;
         end
      end
   end

   // Write one register while idle
   task automatic write_reg(logic [CsrIdxWidth-1:0] idx, bit val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      if (idx == CSR_DIRECTION) conv_board.cfg_direction = val;
      else conv_board.cfg_bypass = val;
      @(negedge clock);
      csr_write <= 0;
   endtask

   // Wait for every outstanding response, then let the pipeline drain
   task automatic drain();
      while (conv_board.want_value.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Send one request, with random idle cycles ahead of it
   task automatic send(logic [31:0] value, logic last);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_value_in <= value;
      req_last_in <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      conv_board.note_request(value, last);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      start <= 0;
      @(negedge clock);
   endtask

   // Random value biased toward interesting exponents
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(5))
         0: v[30:23] = $urandom_range(100, 145);
         1: v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
         2: begin
            v[30:23] = $urandom_range(113, 142);
            v[12:0] = $urandom_range(1) ? 13'h1000 : v[12:0];
         end
         3: v[14:10] = $urandom_range(1) ? 5'h1F : 5'h00;
         default: ;
      endcase
      return v;
   endfunction

   task automatic random_phase(int count, int pct);
      idle_pct = pct;
      for (int i = 0; i < count; i++) send(pick_value(), $urandom_range(1));
      stop_sending();
   endtask

   logic [31:0] directed[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
      32'h7F80_0001, 32'hFFFF_FFFF, 32'h477F_E000, 32'h477F_F000,
      32'h3880_0000, 32'h3380_0000, 32'h3300_0000, 32'h3300_0001,
      32'h0000_0001, 32'h3F80_1000, 32'h3F80_3000, 32'h387F_F000,
      32'hFFFF_03FF, 32'h0000_7C01, 32'h0000_8001, 32'h0000_3C00
   };

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Narrowing and widening over the special values, then bypass
      foreach (directed[i]) send(directed[i], i[0]);
      stop_sending();
      drain();
      write_reg(CSR_DIRECTION, 1);
      foreach (directed[i]) send(directed[i], i[1]);
      stop_sending();
      drain();
      write_reg(CSR_HALF_BYPASS, 1);
      send(32'hFFFF_FFFF, 1);
      send(32'h0000_0000, 0);
      stop_sending();
      drain();

      // Random phases across settings and idle rates
      write_reg(CSR_HALF_BYPASS, 0);
      write_reg(CSR_DIRECTION, 0);
      random_phase(120, 0);
      random_phase(60, 73);
      drain();
      write_reg(CSR_DIRECTION, 1);
      random_phase(80, 25);
      random_phase(60, 0);
      drain();
      write_reg(CSR_HALF_BYPASS, 1);
      random_phase(30, 73);
      drain();
      write_reg(CSR_DIRECTION, 0);
      random_phase(20, 25);
      drain();
      write_reg(CSR_HALF_BYPASS, 0);
      random_phase(40, 0);
      drain();

      if (conv_board.errors == 0 && conv_board.want_value.size() == 0)
         $display("fp32_fp16_converter_tb OK");
      else
         $display("fp32_fp16_converter_tb NOT OK");
      $finish;
   end
endmodule
